// File: src/fsme_pkg.sv
package fsme_pkg;

  localparam int FRAC_BITS = 15;
  localparam int MEMB_W    = 16;
  localparam int CORNER_W  = 16;
  localparam int FUNC_W    = 3;

  typedef logic [MEMB_W-1:0]          memb_t;
  typedef logic signed [CORNER_W-1:0] corner_t;
  typedef logic [FUNC_W-1:0]          func_t;

  localparam memb_t ONE_VAL = MEMB_W'(1) << FRAC_BITS;

  localparam func_t OP_PUSH = 3'd0;
  localparam func_t OP_AND  = 3'd1;
  localparam func_t OP_OR   = 3'd2;
  localparam func_t OP_LDA  = 3'd3;
  localparam func_t OP_TRAP = 3'd4;
  localparam func_t OP_NOT  = 3'd5;
  localparam func_t OP_IF   = 3'd6;

endpackage

// File: src/fsme_channels.sv
interface fsme_in_if;
  logic             valid;
  logic             ready;
  fsme_pkg::func_t   func;
  fsme_pkg::corner_t sample;
  fsme_pkg::corner_t corner_a;
  fsme_pkg::corner_t corner_b;
  fsme_pkg::corner_t corner_c;
  fsme_pkg::corner_t corner_d;
  fsme_pkg::memb_t   immediate;
  logic             last;

  modport source (
    output valid, func, sample, corner_a, corner_b, corner_c, corner_d, immediate, last,
    input  ready
  );
  modport sink (
    input  valid, func, sample, corner_a, corner_b, corner_c, corner_d, immediate, last,
    output ready
  );
endinterface

interface fsme_out_if;
  logic            valid;
  logic            ready;
  fsme_pkg::memb_t membership;
  logic            stack_error;

  modport source (output valid, membership, stack_error, input ready);
  modport sink   (input valid, membership, stack_error, output ready);
endinterface

// File: src/fsme_ram.sv
module fsme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/fsme_div.sv
module fsme_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [fsme_pkg::FRAC_BITS-1:0] quot
);
  import fsme_pkg::*;

  localparam int QW = FRAC_BITS;
  localparam int CW = $clog2(QW);

  logic [15:0]   rem;
  logic [15:0]   den_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [16:0]   rem2;
  logic          qbit;
  logic [16:0]   rem2_sub;

  // one quotient bit per cycle; num < den so the remainder stays below den
  always_comb begin
    rem2     = {rem, 1'b0};
    qbit     = (rem2 >= {1'b0, den_r});
    rem2_sub = qbit ? (rem2 - {1'b0, den_r}) : rem2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(QW-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      cnt   <= '0;
    end else if (busy) begin
      rem  <= rem2_sub[15:0];
      quot <= {quot[QW-2:0], qbit};
      cnt  <= cnt + CW'(1);
    end
  end

endmodule

// File: src/fsme_trap.sv
module fsme_trap (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fsme_pkg::corner_t sample,
  input  fsme_pkg::corner_t corner_a,
  input  fsme_pkg::corner_t corner_b,
  input  fsme_pkg::corner_t corner_c,
  input  fsme_pkg::corner_t corner_d,
  output logic              done,
  output fsme_pkg::memb_t   result
);
  import fsme_pkg::*;

  localparam logic [1:0] EDGE_ZERO = 2'd0;
  localparam logic [1:0] EDGE_ONE  = 2'd1;
  localparam logic [1:0] EDGE_DIV  = 2'd2;

  typedef struct packed {
    logic [1:0]  code;
    logic [15:0] num;
    logic [15:0] den;
  } edge_prep_t;

  function automatic edge_prep_t prep_edge(input logic signed [16:0] num,
                                           input logic signed [16:0] den);
    edge_prep_t         p;
    logic signed [16:0] nn;
    logic signed [16:0] dd;
    nn     = (den < 0) ? -num : num;
    dd     = (den < 0) ? -den : den;
    p.num  = nn[15:0];
    p.den  = dd[15:0];
    if (den == 0) begin
      p.code = (num >= 0) ? EDGE_ONE : EDGE_ZERO;
    end else if (nn <= 0) begin
      p.code = EDGE_ZERO;
    end else if (nn >= dd) begin
      p.code = EDGE_ONE;
    end else begin
      p.code = EDGE_DIV;
    end
    return p;
  endfunction

  function automatic memb_t pick(input logic [1:0] code, input logic [FRAC_BITS-1:0] q);
    memb_t r;
    case (code)
      EDGE_ONE: r = ONE_VAL;
      EDGE_DIV: r = MEMB_W'(q);
      default:  r = '0;
    endcase
    return r;
  endfunction

  edge_prep_t           rise;
  edge_prep_t           fall;
  logic [1:0]           rise_code;
  logic [1:0]           fall_code;
  logic                 rise_done;
  logic                 fall_done;
  logic [FRAC_BITS-1:0] rise_q;
  logic [FRAC_BITS-1:0] fall_q;
  memb_t                r1;
  memb_t                r2;

  always_comb begin
    rise = prep_edge(17'(sample) - 17'(corner_a), 17'(corner_b) - 17'(corner_a));
    fall = prep_edge(17'(corner_d) - 17'(sample), 17'(corner_d) - 17'(corner_c));
    r1   = pick(rise_code, rise_q);
    r2   = pick(fall_code, fall_q);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rise_code <= rise.code;
      fall_code <= fall.code;
    end
  end

  fsme_div u_rise_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (rise.num),
    .den   (rise.den),
    .done  (rise_done),
    .quot  (rise_q)
  );

  fsme_div u_fall_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (fall.num),
    .den   (fall.den),
    .done  (fall_done),
    .quot  (fall_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rise_done & fall_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rise_done & fall_done) begin
      result <= (r1 < r2) ? r1 : r2;
    end
  end

endmodule

// File: src/fuzzy_stack_machine_evaluator_top.sv
// Fuzzy stack-machine evaluator.
// instr carries one instruction word per handshake (opcode, sample, four
// trapezoid corners, Q1.15 immediate, last flag); result carries one word per
// row: the final accumulator and a sticky stack error flag.
// Instructions are taken one at a time. PUSH, AND, OR, LDA, NOT and IF pass
// from acceptance through the execute step to the next ready: the stack
// memory read issued at acceptance returns in the execute step, where the
// update is written back. TRAPMF waits in the trap step for the two
// bit-serial dividers that run in parallel, one quotient bit per cycle over
// FRAC_BITS bits. A result word appears on result in the cycle after the
// last instruction of a row finishes and is held there until taken;
// instructions keep being accepted meanwhile. If another row ends while that
// word still waits, the block holds in its execute step until the word is taken.
// Reset clears the accumulator, stack pointer, error flag and the result
// valid flag; stack memory contents are left as they are and only entries
// written by a push are ever read.
module fuzzy_stack_machine_evaluator_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  fsme_in_if.sink    instr,
  fsme_out_if.source result
);
  import fsme_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TRAP = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]     state;
  logic [1:0]     state_next;
  memb_t          acc;
  memb_t          acc_next;
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_next;
  logic [SPW-1:0] sp_m1;
  logic           err;
  logic           err_next;

  func_t          func_r;
  memb_t          imm_r;
  logic           last_r;

  logic           accept;
  logic           trap_start;
  logic           trap_done;
  memb_t          trap_result;

  logic           ram_we;
  memb_t          ram_rdata;
  memb_t          pop_val;
  logic           pop_ok;
  logic           do_pop;
  logic           commit;

  logic           out_valid;
  memb_t          out_memb;
  logic           out_err;

  assign instr.ready = (state == S_IDLE);
  assign accept      = instr.valid & instr.ready;
  assign trap_start  = accept & (instr.func == OP_TRAP);
  assign sp_m1       = sp - SPW'(1);
  assign pop_ok      = (sp != '0);
  assign pop_val     = pop_ok ? ram_rdata : '0;

  // hold a closing instruction while the previous row's word still waits
  assign commit = (state == S_EXEC) & (~last_r | ~out_valid | result.ready);

  fsme_ram #(
    .WIDTH (MEMB_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp[AW-1:0]),
    .wdata (acc),
    .re    (accept),
    .raddr (sp_m1[AW-1:0]),
    .rdata (ram_rdata)
  );

  fsme_trap u_trap (
    .clk      (clk),
    .rst      (rst),
    .start    (trap_start),
    .sample   (instr.sample),
    .corner_a (instr.corner_a),
    .corner_b (instr.corner_b),
    .corner_c (instr.corner_c),
    .corner_d (instr.corner_d),
    .done     (trap_done),
    .result   (trap_result)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= instr.func;
      imm_r  <= (instr.immediate > ONE_VAL) ? ONE_VAL : instr.immediate;
      last_r <= instr.last;
    end
  end

  always_comb begin
    acc_next = acc;
    sp_next  = sp;
    err_next = err;
    ram_we   = 1'b0;
    do_pop   = 1'b0;
    case (func_r)
      OP_PUSH: begin
        if (sp < SPW'(STACK_DEPTH)) begin
          ram_we  = commit;
          sp_next = sp + SPW'(1);
        end else begin
          err_next = 1'b1;
        end
      end
      OP_AND: begin
        do_pop = 1'b1;
        if (pop_val > acc) begin
          acc_next = pop_val;
        end
      end
      OP_OR: begin
        do_pop = 1'b1;
        if (pop_val < acc) begin
          acc_next = pop_val;
        end
      end
      OP_LDA:  acc_next = imm_r;
      OP_TRAP: acc_next = trap_result;
      OP_NOT:  acc_next = (acc <= ONE_VAL) ? (ONE_VAL - acc) : '0;
      OP_IF: begin
        if (acc > imm_r) begin
          do_pop   = 1'b1;
          acc_next = pop_val;
        end
      end
      default: ;
    endcase
    if (do_pop) begin
      if (pop_ok) begin
        sp_next = sp_m1;
      end else begin
        err_next = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (instr.func == OP_TRAP) ? S_TRAP : S_EXEC;
        end
      end
      S_TRAP: begin
        if (trap_done) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      sp        <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        if (last_r) begin
          // emit the row and clear for the next one
          out_valid <= 1'b1;
          acc       <= '0;
          sp        <= '0;
          err       <= 1'b0;
        end else begin
          acc <= acc_next;
          sp  <= sp_next;
          err <= err_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && last_r) begin
      out_memb <= acc_next;
      out_err  <= err_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.membership  = out_memb;
  assign result.stack_error = out_err;

endmodule

// File: verif/testbench.sv
module testbench;
  import fsme_pkg::*;

  localparam int    STACK_DEPTH = 16;
  localparam func_t OP_NOP      = 3'd7;
  localparam int    HOLD_CYCLES = 300;
  localparam int    CYCLE_LIMIT = 500000;

  typedef struct {
    func_t   func;
    corner_t sample;
    corner_t corner_a;
    corner_t corner_b;
    corner_t corner_c;
    corner_t corner_d;
    memb_t   immediate;
    logic    last;
  } instr_t;

  typedef struct {
    memb_t membership;
    logic  stack_error;
  } row_result_t;

  logic clk = 1'b0;
  logic rst;

  fsme_in_if  instr_ch ();
  fsme_out_if result_ch ();

  fuzzy_stack_machine_evaluator_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk   (clk),
    .rst   (rst),
    .instr (instr_ch),
    .result(result_ch)
  );

  always #6 clk = ~clk;

  // predicted machine state
  memb_t acc_q;
  memb_t stack_q [STACK_DEPTH];
  int    sp_q;
  logic  fault_q;

  row_result_t pending_rows [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int hold_left      = 0;

  int cycle_count  = 0;
  int instr_count  = 0;
  int rows_checked = 0;
  int fault_rows   = 0;
  int mismatches   = 0;

  function automatic memb_t trap_edge(longint num, longint den);
    longint q;
    if (den == 0) return (num >= 0) ? ONE_VAL : memb_t'(0);
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num <= 0) return memb_t'(0);
    if (num >= den) return ONE_VAL;
    q = (num <<< FRAC_BITS) / den;
    return memb_t'(q);
  endfunction

  function automatic memb_t pop_stack();
    if (sp_q == 0) begin
      fault_q = 1'b1;
      return memb_t'(0);
    end
    sp_q--;
    return stack_q[sp_q];
  endfunction

  function automatic void execute_instr(instr_t it);
    memb_t imm_sat;
    memb_t popped;
    memb_t rise;
    memb_t fall;
    row_result_t res;
    imm_sat = (it.immediate > ONE_VAL) ? ONE_VAL : it.immediate;
    case (it.func)
      OP_PUSH: begin
        if (sp_q < STACK_DEPTH) begin
          stack_q[sp_q] = acc_q;
          sp_q++;
        end else begin
          fault_q = 1'b1;
        end
      end
      OP_AND: begin
        popped = pop_stack();
        if (popped > acc_q) acc_q = popped;
      end
      OP_OR: begin
        popped = pop_stack();
        if (popped < acc_q) acc_q = popped;
      end
      OP_LDA: acc_q = imm_sat;
      OP_TRAP: begin
        rise = trap_edge(longint'(it.sample) - longint'(it.corner_a),
                         longint'(it.corner_b) - longint'(it.corner_a));
        fall = trap_edge(longint'(it.corner_d) - longint'(it.sample),
                         longint'(it.corner_d) - longint'(it.corner_c));
        acc_q = (rise < fall) ? rise : fall;
      end
      OP_NOT: acc_q = (acc_q <= ONE_VAL) ? ONE_VAL - acc_q : memb_t'(0);
      OP_IF: begin
        if (acc_q > imm_sat) acc_q = pop_stack();
      end
      default: ;
    endcase
    if (it.last) begin
      res.membership  = acc_q;
      res.stack_error = fault_q;
      pending_rows    = {pending_rows, res};
      if (fault_q) fault_rows++;
      acc_q   = '0;
      sp_q    = 0;
      fault_q = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_instr(input instr_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      instr_ch.valid = 1'b0;
      @(negedge clk);
    end
    instr_ch.valid     = 1'b1;
    instr_ch.func      = it.func;
    instr_ch.sample    = it.sample;
    instr_ch.corner_a  = it.corner_a;
    instr_ch.corner_b  = it.corner_b;
    instr_ch.corner_c  = it.corner_c;
    instr_ch.corner_d  = it.corner_d;
    instr_ch.immediate = it.immediate;
    instr_ch.last      = it.last;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    execute_instr(it);
    instr_count++;
    @(negedge clk);
  endtask

  task automatic send_op(input func_t f, input int imm, input logic lst);
    instr_t it;
    it = '{func: f, sample: '0, corner_a: '0, corner_b: '0, corner_c: '0,
           corner_d: '0, immediate: memb_t'(imm), last: lst};
    send_instr(it);
  endtask

  task automatic send_trap(input int s, input int a, input int b, input int c,
                           input int d, input logic lst);
    instr_t it;
    it = '{func: OP_TRAP, sample: corner_t'(s), corner_a: corner_t'(a),
           corner_b: corner_t'(b), corner_c: corner_t'(c), corner_d: corner_t'(d),
           immediate: memb_t'($urandom_range(0, 65535)), last: lst};
    send_instr(it);
  endtask

  function automatic instr_t make_instr(func_t f, logic lst);
    instr_t it;
    int style;
    int pts [$];
    style = $urandom_range(3);
    for (int i = 0; i < 4; i++) begin
      if (style == 3) pts = {pts, int'($urandom_range(0, 200)) - 100};
      else pts = {pts, int'($urandom_range(0, 65535)) - 32768};
    end
    pts.sort();
    if (style == 2) begin
      // collapse an edge to zero width
      case ($urandom_range(2))
        0: pts[1] = pts[0];
        1: pts[3] = pts[2];
        default: pts[2] = pts[1];
      endcase
    end
    it.func = f;
    it.last = lst;
    if (style == 0) begin
      // unordered corners, reversed edges likely
      it.corner_a = corner_t'($urandom);
      it.corner_b = corner_t'($urandom);
      it.corner_c = corner_t'($urandom);
      it.corner_d = corner_t'($urandom);
    end else begin
      it.corner_a = corner_t'(pts[0]);
      it.corner_b = corner_t'(pts[1]);
      it.corner_c = corner_t'(pts[2]);
      it.corner_d = corner_t'(pts[3]);
    end
    if ($urandom_range(4) == 0) it.sample = corner_t'($urandom);
    else it.sample = corner_t'(pts[0] + int'($urandom_range(0, pts[3] - pts[0])));
    if ($urandom_range(6) == 0) it.immediate = memb_t'($urandom_range(0, 65535));
    else it.immediate = memb_t'($urandom_range(0, 32768));
    return it;
  endfunction

  task automatic send_random_row();
    int    kind;
    int    len;
    int    depth;
    int    r;
    func_t f;
    kind  = $urandom_range(99);
    len   = (kind < 8) ? $urandom_range(15, 22) : $urandom_range(1, 10);
    depth = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (kind < 8) begin
        // push-heavy row to reach a full stack
        if (r < 65) f = OP_PUSH;
        else if (r < 80) f = (r < 72) ? OP_AND : OP_OR;
        else f = (r < 90) ? OP_LDA : OP_TRAP;
      end else if (kind < 20) begin
        f = func_t'($urandom_range(0, 7));
      end else begin
        // pop only what was pushed
        if (r < 22) f = OP_PUSH;
        else if (r < 42) f = (depth > 0) ? ((r < 32) ? OP_AND : OP_OR) : OP_LDA;
        else if (r < 56) f = OP_LDA;
        else if (r < 76) f = OP_TRAP;
        else if (r < 86) f = OP_NOT;
        else if (r < 97) f = (depth > 0) ? OP_IF : OP_NOT;
        else f = OP_NOP;
      end
      if (f == OP_PUSH && depth < STACK_DEPTH) depth++;
      else if ((f == OP_AND || f == OP_OR || f == OP_IF) && depth > 0) depth--;
      send_instr(make_instr(f, i == len - 1));
    end
  endtask

  task automatic test_basic_ops();
    send_op(OP_LDA, 16384, 1'b0);
    send_op(OP_PUSH, 0, 1'b0);
    send_op(OP_LDA, 8192, 1'b0);
    send_op(OP_AND, 0, 1'b1);
    send_op(OP_LDA, 16384, 1'b0);
    send_op(OP_PUSH, 0, 1'b0);
    send_op(OP_LDA, 8192, 1'b0);
    send_op(OP_OR, 0, 1'b0);
    send_op(OP_NOT, 0, 1'b1);
    // load saturates, then IF compare against saturated constant holds
    send_op(OP_LDA, 65535, 1'b0);
    send_op(OP_PUSH, 0, 1'b0);
    send_op(OP_IF, 40000, 1'b0);
    send_op(OP_NOT, 0, 1'b1);
  endtask

  task automatic test_empty_stack();
    send_op(OP_LDA, 5000, 1'b0);
    send_op(OP_AND, 0, 1'b0);
    send_op(OP_OR, 0, 1'b0);
    send_op(OP_LDA, 100, 1'b0);
    send_op(OP_IF, 0, 1'b0);
    send_op(OP_NOT, 0, 1'b1);
  endtask

  task automatic test_trapezoid_edges();
    send_trap(-32768, -32768, -32768, 32767, 32767, 1'b1);
    send_trap(-1, -32768, 0, 0, 32767, 1'b1);
    send_trap(50, 100, 0, 200, 300, 1'b1);
    send_trap(-5, 0, 0, 10, 20, 1'b1);
    send_op(OP_NOP, 0, 1'b1);
  endtask

  task automatic test_stack_overflow();
    send_op(OP_LDA, 12345, 1'b0);
    for (int i = 0; i <= STACK_DEPTH; i++) send_op(OP_PUSH, 0, 1'b0);
    send_op(OP_AND, 32768, 1'b1);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle, input int stall);
    int stop_at;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    stop_at        = instr_count + n_items;
    while (instr_count < stop_at) send_random_row();
  endtask

  task automatic test_backpressure();
    int stop_at;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    stop_at        = instr_count + 60;
    // short rows so results pile up behind the held receiver
    while (instr_count < stop_at) begin
      send_op(OP_LDA, $urandom_range(0, 32768), 1'b0);
      send_op(OP_NOT, 0, 1'b1);
    end
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        result_ch.ready = 1'b0;
        hold_left--;
      end else begin
        result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    row_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected word membership=%0d stack_error=%0b",
                                  result_ch.membership, result_ch.stack_error));
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (result_ch.membership !== want.membership)
          report_mismatch($sformatf("row %0d membership got %0d want %0d", rows_checked,
                                    result_ch.membership, want.membership));
        if (result_ch.stack_error !== want.stack_error)
          report_mismatch($sformatf("row %0d stack_error got %0b want %0b", rows_checked,
                                    result_ch.stack_error, want.stack_error));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows outstanding", cycle_count,
               pending_rows.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    instr_ch.valid     = 1'b0;
    instr_ch.func      = OP_PUSH;
    instr_ch.sample    = '0;
    instr_ch.corner_a  = '0;
    instr_ch.corner_b  = '0;
    instr_ch.corner_c  = '0;
    instr_ch.corner_d  = '0;
    instr_ch.immediate = '0;
    instr_ch.last      = 1'b0;
    acc_q              = '0;
    sp_q               = 0;
    fault_q            = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_ops();
    test_empty_stack();
    test_trapezoid_edges();
    test_stack_overflow();
    test_random_traffic(235, 0, 0);
    test_random_traffic(235, 54, 0);
    test_random_traffic(235, 0, 54);
    test_random_traffic(235, 17, 17);
    test_backpressure();
    instr_ch.valid = 1'b0;
    recv_stall_pct = 0;

    wait (pending_rows.size() == 0 && hold_left == 0);
    repeat (40) @(posedge clk);
    $display("%0d instructions over %0d checked rows, %0d rows with stack faults",
             instr_count, rows_checked, fault_rows);
    $display("free flow, sparse sender, stalled receiver, mixed and a long result hold-off");
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
